FILE: src/bol_pkg.sv
// Package: shared types and constants for the bounded ordered list.
`timescale 1ns / 1ps
`default_nettype none
package bol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_BACK  = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_BACK  = 3'd4,
    CMD_REM_EQUAL = 3'd5,
    CMD_QUERY     = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PURGE = 1'b1
  } state_t;

  typedef enum logic [2:0] {
    CO_HOLD,
    CO_SHR_ALL,
    CO_SHL_ALL,
    CO_INSERT,
    CO_SHL_MATCH
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic                       ordered;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [DATA_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;
    logic signed [DATA_W-1:0]   front_value;
    logic signed [DATA_W-1:0]   back_value;
    logic                       is_empty;
    logic                       found;
  } out_item_t;

endpackage
`default_nettype wire

FILE: src/bol_cell.sv
// One storage cell of the list chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module bol_cell
  import bol_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic [$clog2(CAPACITY+1)-1:0] fill,
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic signed [DATA_W-1:0] right_val,
  input  wire logic                     hit_in,
  output logic                          hit_out,
  output logic                          match,
  output logic signed [DATA_W-1:0]      val
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam logic [FW-1:0] IDX_F = FW'(IDX);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     occ;
  logic                     at_tail;
  logic                     ge;

  assign occ     = (fill > IDX_F);
  assign at_tail = (fill == IDX_F);
  assign match   = occ && (entry_r == ctl.value);
  assign ge      = occ && ctl.ordered && (entry_r >= ctl.value);
  assign val     = entry_r;

  always_comb begin
    hit_out   = 1'b0;
    entry_nxt = entry_r;
    case (ctl.op)
      CO_SHR_ALL: entry_nxt = left_val;
      CO_SHL_ALL: entry_nxt = right_val;
      CO_INSERT: begin
        hit_out = hit_in || ge;
        if (hit_in) begin
          entry_nxt = left_val;
        end else if (ge || at_tail) begin
          entry_nxt = ctl.value;
        end
      end
      CO_SHL_MATCH: begin
        hit_out = hit_in || match;
        if (hit_in || match) begin
          entry_nxt = right_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

FILE: src/bounded_ordered_list_top.sv
// Top level: bounded ordered list built from a chain of storage cells.
// Result: the strobe is registered and comes in the cycle after the command is accepted;
// remove-equal with matches strobes once the purge state finds no matching entry left.
// Throughput: one command per cycle while not busy; remove-equal with matches holds busy
// until every match is gone, one matching entry dropped per cycle by the shift chain.
// Reset: fill count cleared to zero, entries left undefined; no clearing pass.
// Results cannot be stalled: out_valid pulses for one cycle per command.
`timescale 1ns / 1ps
`default_nettype none
module bounded_ordered_list_top
  import bol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_valid,
  output out_item_t     out_data
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [FW-1:0] FULL_F = FW'(CAPACITY);
  localparam logic [FW-1:0] ONE_F  = FW'(1);

  state_t                   state_r, state_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     found_r, found_nxt;
  logic signed [DATA_W-1:0] value_r;

  logic                     accept;
  logic                     any_match;
  logic                     full;
  logic                     empty;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] vals [CAPACITY];
  logic                     hit [CAPACITY+1];
  logic [CAPACITY-1:0]      match_vec;
  logic [IW-1:0]            back_idx;

  assign busy      = (state_r == S_PURGE);
  assign accept    = start && !busy;
  assign any_match = |match_vec;
  assign full      = (fill_r == FULL_F);
  assign empty     = (fill_r == '0);
  assign hit[0]    = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (g == 0) begin : g_head
      assign left_v = ctl.value;
    end else begin : g_mid
      assign left_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_body
      assign right_v = vals[g+1];
    end
    bol_cell #(
      .IDX      (g),
      .CAPACITY (CAPACITY)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill_r),
      .left_val  (left_v),
      .right_val (right_v),
      .hit_in    (hit[g]),
      .hit_out   (hit[g+1]),
      .match     (match_vec[g]),
      .val       (vals[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (cmd_t'(in_data.cmd) == CMD_REM_EQUAL) && any_match) begin
          state_nxt = S_PURGE;
        end
      end
      S_PURGE: begin
        if (!any_match) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op        = CO_HOLD;
    ctl.ordered   = 1'b0;
    ctl.value     = (state_r == S_PURGE) ? value_r : in_data.value;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    found_nxt     = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          found_nxt  = any_match;
          status_nxt = STATUS_OK;
          unique case (cmd_t'(in_data.cmd)) inside
            CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                status_nxt = STATUS_FULL;
              end else begin
                fill_nxt = fill_r + ONE_F;
                if (cmd_t'(in_data.cmd) == CMD_ADD_FRONT) begin
                  ctl.op = CO_SHR_ALL;
                end else begin
                  ctl.op      = CO_INSERT;
                  ctl.ordered = (cmd_t'(in_data.cmd) == CMD_INSERT);
                end
              end
            end
            CMD_REM_FRONT, CMD_REM_BACK: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                fill_nxt = fill_r - ONE_F;
                if (cmd_t'(in_data.cmd) == CMD_REM_FRONT) begin
                  ctl.op = CO_SHL_ALL;
                end
              end
            end
            CMD_REM_EQUAL: begin
              if (any_match) begin
                ctl.op   = CO_SHL_MATCH;
                fill_nxt = fill_r - ONE_F;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_PURGE: begin
        if (any_match) begin
          ctl.op   = CO_SHL_MATCH;
          fill_nxt = fill_r - ONE_F;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
    if (accept) begin
      value_r <= in_data.value;
    end
  end

  assign back_idx = IW'(fill_r - ONE_F);

  assign out_valid            = out_valid_r;
  assign out_data.status      = status_r;
  assign out_data.count       = COUNT_W'(fill_r);
  assign out_data.front_value = empty ? '0 : vals[0];
  assign out_data.back_value  = empty ? '0 : vals[back_idx];
  assign out_data.is_empty    = empty;
  assign out_data.found       = found_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_F)
    else $error("fill count above capacity");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(accept) || $past(state_r == S_PURGE)))
    else $error("result strobe without a transaction");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STATUS_FULL)) |-> full)
    else $error("full status while list not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STATUS_EMPTY)) |-> empty)
    else $error("empty status while list not empty");

  a_purge_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PURGE) && any_match) |=> (fill_r == $past(fill_r) - ONE_F))
    else $error("remove-equal step did not drop one entry");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for bounded_ordered_list_top: directed table, then weighted random commands.
`timescale 1ns / 1ps
module tb;
  import bol_pkg::*;

  localparam int CAPACITY      = CAPACITY_DEF;
  localparam int RAND_ITEMS    = 1850;
  localparam int QUIET_TAIL    = 300;
  localparam int SEG_LEN       = 60;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int TAIL_CYCLES   = 4;
  localparam int N_DIR         = 23;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic signed [DATA_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] V_ONE = 32'sd1;
  localparam logic signed [DATA_W-1:0] V_NEG = -32'sd1;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    int                       reps;
    bit                       typed;
    out_item_t                want;
  } dir_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  bit        typed_on = 1'b0;
  out_item_t typed_want = '0;

  logic signed [DATA_W-1:0] list_q[$];
  out_item_t                pending_results[$];

  int err_count;
  int n_accepted;
  int n_full_rejects;
  int n_empty_rejects;
  int n_dropped;
  int n_hits;
  int quiet_cycles;

  dir_row_t dir_rows [N_DIR];

  bounded_ordered_list_top #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t mk_res(status_t st, int cnt, logic signed [DATA_W-1:0] fr,
                                       logic signed [DATA_W-1:0] bk, bit emp, bit fnd);
    out_item_t r;
    r.status      = st;
    r.count       = COUNT_W'(cnt);
    r.front_value = fr;
    r.back_value  = bk;
    r.is_empty    = emp;
    r.found       = fnd;
    return r;
  endfunction

  // apply one command to the list copy and return the resulting snapshot
  function automatic out_item_t apply_cmd(in_item_t it);
    out_item_t                r;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] kept[$];
    int                       pos;
    v = it.value;
    r = '0;
    r.status = STATUS_OK;
    foreach (list_q[i])
      if (list_q[i] == v) r.found = 1'b1;
    case (it.cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
        if (list_q.size() >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (it.cmd == CMD_ADD_FRONT) begin
          list_q.push_front(v);
        end else if (it.cmd == CMD_ADD_BACK) begin
          list_q.insert(list_q.size(), v);
        end else begin
          pos = 0;
          while (pos < list_q.size() && list_q[pos] < v) pos++;
          list_q.insert(pos, v);
        end
      end
      CMD_REM_FRONT: begin
        if (list_q.size() == 0) r.status = STATUS_EMPTY;
        else void'(list_q.pop_front());
      end
      CMD_REM_BACK: begin
        if (list_q.size() == 0) r.status = STATUS_EMPTY;
        else list_q.delete(list_q.size() - 1);
      end
      CMD_REM_EQUAL: begin
        foreach (list_q[i])
          if (list_q[i] != v) kept.insert(kept.size(), list_q[i]);
        n_dropped += list_q.size() - kept.size();
        list_q = kept;
      end
      default: begin
      end
    endcase
    r.count    = COUNT_W'(list_q.size());
    r.is_empty = (list_q.size() == 0);
    if (list_q.size() != 0) begin
      r.front_value = list_q[0];
      r.back_value  = list_q[list_q.size() - 1];
    end
    return r;
  endfunction

  task automatic report(string what, out_item_t want, out_item_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch (%s) at %0t: expected st=%0d cnt=%0d front=%0d back=%0d emp=%0b fnd=%0b,",
               what, $realtime, want.status, want.count, want.front_value, want.back_value,
               want.is_empty, want.found);
    if (err_count <= MAX_REPORTS)
      $display("  got st=%0d cnt=%0d front=%0d back=%0d emp=%0b fnd=%0b",
               got.status, got.count, got.front_value, got.back_value, got.is_empty, got.found);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    string     bad;
    bad = "";
    if (pending_results.size() == 0) begin
      report("result with no pending transaction", '0, got);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)           bad = {bad, " status"};
      if (got.count !== want.count)             bad = {bad, " count"};
      if (got.front_value !== want.front_value) bad = {bad, " front_value"};
      if (got.back_value !== want.back_value)   bad = {bad, " back_value"};
      if (got.is_empty !== want.is_empty)       bad = {bad, " is_empty"};
      if (got.found !== want.found)             bad = {bad, " found"};
      if (bad != "") report({"field", bad}, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_item_t snap;
      if (out_valid) check_result(out_data);
      if (start && !busy) begin
        snap = apply_cmd(in_data);
        n_accepted++;
        if (snap.status == STATUS_FULL)  n_full_rejects++;
        if (snap.status == STATUS_EMPTY) n_empty_rejects++;
        if (snap.found)                  n_hits++;
        pending_results.insert(pending_results.size(), typed_on ? typed_want : snap);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it, bit typed, out_item_t want);
    start      <= 1'b1;
    in_data    <= it;
    typed_on   <= typed;
    typed_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] v;
    int                       k;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      v = $urandom_range(0, 7);
      v = v - 4;
    end else if (k < 7) begin
      case ($urandom_range(0, 3))
        0:       v = V_MIN;
        1:       v = V_MAX;
        2:       v = '0;
        default: v = V_NEG;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  // mode 0 leans to adding, mode 1 to removing, mode 2 is flat
  function automatic logic [CMD_W-1:0] rand_cmd(int mode);
    int p;
    p = $urandom_range(0, 99);
    if (mode == 2) return CMD_W'($urandom_range(0, 7));
    if (p < (mode == 0 ? 70 : 25)) return CMD_W'($urandom_range(CMD_ADD_FRONT, CMD_INSERT));
    if (p < (mode == 0 ? 95 : 85)) return CMD_W'($urandom_range(CMD_REM_FRONT, CMD_REM_EQUAL));
    return ($urandom_range(0, 1) != 0) ? CMD_QUERY : CMD_UNUSED;
  endfunction

  initial begin
    in_item_t it;
    int       mode;
    bit       bursty;

    dir_rows = '{
      '{CMD_QUERY,     '0,    1,  1'b1, mk_res(STATUS_OK,    0,  '0,    '0,    1'b1, 1'b0)},
      '{CMD_REM_FRONT, '0,    1,  1'b1, mk_res(STATUS_EMPTY, 0,  '0,    '0,    1'b1, 1'b0)},
      '{CMD_REM_BACK,  '0,    1,  1'b1, mk_res(STATUS_EMPTY, 0,  '0,    '0,    1'b1, 1'b0)},
      '{CMD_REM_EQUAL, V_ONE, 1,  1'b1, mk_res(STATUS_OK,    0,  '0,    '0,    1'b1, 1'b0)},
      '{CMD_INSERT,    V_ONE, 1,  1'b1, mk_res(STATUS_OK,    1,  V_ONE, V_ONE, 1'b0, 1'b0)},
      '{CMD_REM_BACK,  '0,    1,  1'b1, mk_res(STATUS_OK,    0,  '0,    '0,    1'b1, 1'b0)},
      '{CMD_ADD_BACK,  V_MAX, 1,  1'b1, mk_res(STATUS_OK,    1,  V_MAX, V_MAX, 1'b0, 1'b0)},
      '{CMD_ADD_FRONT, V_MIN, 1,  1'b1, mk_res(STATUS_OK,    2,  V_MIN, V_MAX, 1'b0, 1'b0)},
      '{CMD_INSERT,    '0,    1,  1'b1, mk_res(STATUS_OK,    3,  V_MIN, V_MAX, 1'b0, 1'b0)},
      '{CMD_INSERT,    '0,    1,  1'b1, mk_res(STATUS_OK,    4,  V_MIN, V_MAX, 1'b0, 1'b1)},
      '{CMD_INSERT,    V_MAX, 1,  1'b0, '0},
      '{CMD_INSERT,    V_MIN, 1,  1'b0, '0},
      '{CMD_QUERY,     V_MAX, 1,  1'b0, '0},
      '{CMD_UNUSED,    '0,    1,  1'b0, '0},
      '{CMD_REM_EQUAL, '0,    1,  1'b1, mk_res(STATUS_OK,    4,  V_MIN, V_MAX, 1'b0, 1'b1)},
      '{CMD_ADD_BACK,  V_NEG, 12, 1'b0, '0},
      '{CMD_ADD_FRONT, V_ONE, 1,  1'b1, mk_res(STATUS_FULL,  16, V_MIN, V_NEG, 1'b0, 1'b0)},
      '{CMD_INSERT,    V_NEG, 1,  1'b1, mk_res(STATUS_FULL,  16, V_MIN, V_NEG, 1'b0, 1'b1)},
      '{CMD_ADD_BACK,  V_ONE, 1,  1'b1, mk_res(STATUS_FULL,  16, V_MIN, V_NEG, 1'b0, 1'b0)},
      '{CMD_REM_EQUAL, V_NEG, 1,  1'b1, mk_res(STATUS_OK,    4,  V_MIN, V_MAX, 1'b0, 1'b1)},
      '{CMD_REM_FRONT, '0,    1,  1'b0, '0},
      '{CMD_REM_EQUAL, V_MIN, 1,  1'b0, '0},
      '{CMD_REM_FRONT, '0,    1,  1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      it.cmd   = dir_rows[r].cmd;
      it.value = dir_rows[r].value;
      repeat (dir_rows[r].reps) send(it, dir_rows[r].typed, dir_rows[r].want);
    end
    drain();

    mode   = 0;
    bursty = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % SEG_LEN == 0) begin
        mode   = $urandom_range(0, 2);
        bursty = ($urandom_range(0, 2) != 0);
      end
      if (n == RAND_ITEMS / 2) drain();
      it.cmd   = rand_cmd(mode);
      it.value = rand_value();
      send(it, 1'b0, '0);
      if (n < RAND_ITEMS - QUIET_TAIL && bursty && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 4));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d full-list rejects, %0d empty-list rejects,",
             n_accepted, n_full_rejects, n_empty_rejects);
    $display("  %0d entries dropped by remove-equal, %0d lookups found, %0d mismatches",
             n_dropped, n_hits, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
